@@ hw/rtl/tlds_pkg.sv @@
// Shared types and constants for the two-wire LED driver serial sender.
package tlds_pkg;

	localparam int DIGITS_DEF = 4;          // digit bytes in a data frame
	localparam int DIGIT_FIELDS = 4;        // digit fields carried by an input beat
	localparam int QLEN_W = 16;
	localparam int TICK_W = QLEN_W + 1;     // holds a half period
	localparam int BIT_IDX_W = 4;
	localparam int BYTE_IDX_W = 3;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W = 48;          // 42 payload bits padded to bytes
	localparam int OUT_DATA_W = 8;          // 5 payload bits padded to a byte

	localparam logic [BIT_IDX_W-1:0] BITS_PER_BYTE = 4'd8;
	localparam logic [7:0] LSB_MASK = 8'h01;

	localparam logic [QLEN_W-1:0] QUARTER_LEN_RST = 16'd100;
	localparam logic [7:0] ADDRESS_CMD_RST = 8'd192;

	localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_LEN = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_CMD = 8'd1;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_CMD  = 2'd1,
		OP_DATA = 2'd2
	} op_t;

	// packed so that clk_drive_low sits in bit 0
	typedef struct packed {
		logic frame_done;
		logic rejected;
		logic busy_res;
		logic dio_drive_low;
		logic clk_drive_low;
	} res_t;

endpackage

@@ hw/rtl/tlds_frame_seq.sv @@
// Frame sequencer: start, bytes with acknowledge clock, stop; one tick per step.
module tlds_frame_seq #(
	parameter int DIGITS = tlds_pkg::DIGITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic [1:0]                          operation,
	input  logic [7:0]                          command_byte,
	input  logic [tlds_pkg::DIGIT_FIELDS-1:0][7:0] digits,
	input  logic [tlds_pkg::QLEN_W-1:0]         quarter_len,
	input  logic [7:0]                          address_cmd,
	output tlds_pkg::res_t                      res
);

	localparam int FRAME_MAX = DIGITS + 1;
	localparam int IDX_W = $clog2(FRAME_MAX);
	localparam logic [tlds_pkg::BYTE_IDX_W-1:0] DATA_BYTES =
		tlds_pkg::BYTE_IDX_W'(FRAME_MAX);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_START = 3'd1,
		PH_BITS  = 3'd2,
		PH_ACK   = 3'd3,
		PH_STOP  = 3'd4
	} phase_t;

	phase_t                              phase_q, ph, n_ph;
	logic [1:0]                          step_q, st, n_st;
	logic [tlds_pkg::TICK_W-1:0]         tick_q, tick, tick_inc, n_tick, seg_len, half;
	logic [tlds_pkg::QLEN_W-1:0]         quarter;
	logic [tlds_pkg::BIT_IDX_W-1:0]      bit_q, n_bit, bit_inc;
	logic [tlds_pkg::BYTE_IDX_W-1:0]     byte_q, n_byte, byte_inc, bytes_in_frame;
	logic [7:0]                          shift_q, n_shift;
	logic                                data_frame_q;
	logic                                clk_low_q, dio_low_q, clk_l, dio_l, n_clk, n_dio;
	logic [FRAME_MAX-1:0][7:0]           frame_q, frame_d;
	logic                                request, start_frame, done;

	assign request = step && (operation == tlds_pkg::OP_CMD || operation == tlds_pkg::OP_DATA);
	assign start_frame = request && (phase_q == PH_IDLE);
	assign bytes_in_frame = data_frame_q ? DATA_BYTES : 3'd1;

	// bytes captured at frame start; digit bytes past the input fields are zero
	assign frame_d[0] = (operation == tlds_pkg::OP_CMD) ? command_byte : address_cmd;
	for (genvar i = 1; i < FRAME_MAX; i++) begin : g_frame
		if (i <= tlds_pkg::DIGIT_FIELDS) begin : g_digit
			assign frame_d[i] = digits[i-1];
		end else begin : g_zero
			assign frame_d[i] = '0;
		end
	end

	assign quarter = (quarter_len == '0) ? tlds_pkg::QLEN_W'(1) : quarter_len;
	assign half = {quarter, 1'b0};

	always_comb begin
		// a request on an idle tick opens the start condition on that tick
		ph = phase_q;
		st = step_q;
		tick = tick_q;
		clk_l = clk_low_q;
		dio_l = dio_low_q;
		if (start_frame) begin
			ph = PH_START;
			st = 2'd0;
			tick = '0;
			clk_l = 1'b0;
			dio_l = 1'b0;
		end

		case (ph)
			PH_START: seg_len = half;
			PH_BITS:  seg_len = (st == 2'd2) ? half : {1'b0, quarter};
			PH_ACK:   seg_len = (st == 2'd0) ? half : {1'b0, quarter};
			PH_STOP:  seg_len = (st >= 2'd2) ? half : {1'b0, quarter};
			default:  seg_len = {1'b0, quarter};
		endcase

		tick_inc = tick + 1'b1;
		bit_inc = bit_q + 1'b1;
		byte_inc = byte_q + 1'b1;

		n_ph = ph;
		n_st = st;
		n_tick = tick;
		n_bit = bit_q;
		n_byte = byte_q;
		n_shift = shift_q;
		n_clk = clk_l;
		n_dio = dio_l;
		done = 1'b0;

		if (ph != PH_IDLE) begin
			n_tick = tick_inc;
			if (tick_inc >= seg_len) begin
				n_tick = '0;
				case (ph)
					PH_START: begin
						if (st == 2'd0) begin
							n_st = 2'd1;
						end else begin
							n_byte = '0;
							n_shift = frame_q[0];
							n_bit = '0;
							n_ph = PH_BITS;
							n_st = 2'd0;
						end
					end
					PH_BITS: begin
						if (st < 2'd2) begin
							n_st = st + 1'b1;
						end else begin
							n_shift = shift_q >> 1;
							n_bit = bit_inc;
							n_ph = (bit_inc < tlds_pkg::BITS_PER_BYTE) ? PH_BITS : PH_ACK;
							n_st = 2'd0;
						end
					end
					PH_ACK: begin
						if (st < 2'd2) begin
							n_st = st + 1'b1;
						end else begin
							n_byte = byte_inc;
							n_st = 2'd0;
							if (byte_inc < bytes_in_frame) begin
								n_shift = frame_q[byte_inc[IDX_W-1:0]];
								n_bit = '0;
								n_ph = PH_BITS;
							end else begin
								n_ph = PH_STOP;
							end
						end
					end
					PH_STOP: begin
						if (st < 2'd3) begin
							n_st = st + 1'b1;
						end else begin
							n_ph = PH_IDLE;
							n_st = 2'd0;
							done = 1'b1;
						end
					end
					default: begin
						n_ph = PH_IDLE;
						n_st = 2'd0;
					end
				endcase

				// line levels held by the segment just entered
				case (n_ph)
					PH_START: begin
						n_clk = 1'b0;
						n_dio = (n_st != 2'd0);
					end
					PH_BITS: begin
						if (n_st == 2'd0) n_clk = 1'b1;
						else if (n_st == 2'd1) n_dio = ((n_shift & tlds_pkg::LSB_MASK) == '0);
						else n_clk = 1'b0;
					end
					PH_ACK: begin
						if (n_st == 2'd0) begin
							n_clk = 1'b1;
							n_dio = 1'b0;
						end else if (n_st == 2'd1) begin
							n_clk = 1'b0;
						end else begin
							n_dio = 1'b1;
						end
					end
					PH_STOP: begin
						if (n_st == 2'd0) n_clk = 1'b1;
						else if (n_st == 2'd1) n_dio = 1'b1;
						else if (n_st == 2'd2) n_clk = 1'b0;
						else n_dio = 1'b0;
					end
					default: begin
						n_clk = 1'b0;
						n_dio = 1'b0;
					end
				endcase
			end
		end

		res.clk_drive_low = clk_l;
		res.dio_drive_low = dio_l;
		res.busy_res = (ph != PH_IDLE);
		res.rejected = request && (phase_q != PH_IDLE);
		res.frame_done = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			step_q <= '0;
			tick_q <= '0;
			bit_q <= '0;
			byte_q <= '0;
			shift_q <= '0;
			data_frame_q <= 1'b0;
			clk_low_q <= 1'b0;
			dio_low_q <= 1'b0;
		end else if (step) begin
			phase_q <= n_ph;
			step_q <= n_st;
			tick_q <= n_tick;
			bit_q <= n_bit;
			byte_q <= n_byte;
			shift_q <= n_shift;
			clk_low_q <= n_clk;
			dio_low_q <= n_dio;
			if (start_frame) data_frame_q <= (operation == tlds_pkg::OP_DATA);
		end
	end

	always_ff @(posedge clk) begin
		if (start_frame) frame_q <= frame_d;
	end

endmodule

@@ hw/rtl/two_wire_led_driver_serial_sender.sv @@
// Top level: stream handshake, configuration registers and result register.
//
//  channel  dir  beat fields (low bit up)
//  s_*      in   operation, command_byte, digit_first..digit_fourth
//  m_*      out  clk_drive_low, dio_drive_low, busy_res, rejected, frame_done
//  cfg_*    in   index 0 quarter_len, index 1 address_cmd
//
// One input beat is one line tick; a beat is taken every cycle unless input is
// held off; its result appears in the output register on the next cycle. The
// sequencer state and the result register advance together on each accepted beat.
// Input is held off only while the result register is full and not taken.
// Reset: quarter_len 100, address_cmd 192, sender idle, both lines released.
module two_wire_led_driver_serial_sender #(
	parameter int DIGITS = tlds_pkg::DIGITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// operation[1:0], command_byte[9:2], digit_first[17:10], digit_second[25:18],
	// digit_third[33:26], digit_fourth[41:34], zeros above
	input  logic [tlds_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// clk_drive_low[0], dio_drive_low[1], busy_res[2], rejected[3], frame_done[4]
	output logic [tlds_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tlds_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tlds_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [tlds_pkg::QLEN_W-1:0]                quarter_len_q;
	logic [7:0]                                 address_cmd_q;
	logic                                       in_beat;
	logic                                       out_valid_q;
	tlds_pkg::res_t                             res, res_q;
	logic [tlds_pkg::DIGIT_FIELDS-1:0][7:0]     digits;

	assign cfg_ready = 1'b1;
	assign s_tready = !out_valid_q || m_tready;
	assign in_beat = s_tvalid && s_tready;

	assign digits = {s_tdata[41:34], s_tdata[33:26], s_tdata[25:18], s_tdata[17:10]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quarter_len_q <= tlds_pkg::QUARTER_LEN_RST;
			address_cmd_q <= tlds_pkg::ADDRESS_CMD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tlds_pkg::CFG_QUARTER_LEN: quarter_len_q <= cfg_data;
				tlds_pkg::CFG_ADDRESS_CMD: address_cmd_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	tlds_frame_seq #(
		.DIGITS(DIGITS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (in_beat),
		.operation    (s_tdata[1:0]),
		.command_byte (s_tdata[9:2]),
		.digits       (digits),
		.quarter_len  (quarter_len_q),
		.address_cmd  (address_cmd_q),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_beat) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {3'b000, res_q};

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.rejected |-> res_q.busy_res)
		else $error("rejected request reported on an idle tick");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.frame_done |-> res_q.busy_res)
		else $error("frame_done outside a frame");

	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.busy_res |-> !res_q.clk_drive_low && !res_q.dio_drive_low)
		else $error("line pulled low while idle");

	a_beat_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> out_valid_q)
		else $error("accepted beat produced no result");

endmodule
